FILE: src/rsmp_pkg.sv
// Shared types, constants and register codes for the linear interpolation resampler.
package rsmp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 18;
  localparam int CHAN_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_FRAMES_LOG2_DEF = 24;
  localparam int MAX_RUN_DEF         = 64;

  // Blend numerator: sample times rate plus sample difference times fraction.
  localparam int BLEND_W     = SAMPLE_W + RATE_W + 3;
  localparam int BLEND_MAG_W = BLEND_W - 1;

  localparam logic [RATE_W-1:0] SRC_RATE_RST  = RATE_W'(48000);
  localparam logic [RATE_W-1:0] DST_RATE_RST  = RATE_W'(48000);
  localparam logic [CHAN_W-1:0] CHANNELS_RST  = CHAN_W'(2);
  localparam logic [CHAN_W-1:0] CHAN_MONO     = CHAN_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DST_RATE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = CFG_IDX_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY,
    ST_TOT_MUL,
    ST_TOT_DIV,
    ST_TOT_WAIT,
    ST_PEND,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_POS_WAIT,
    ST_CHECK,
    ST_BLEND,
    ST_PLACE,
    ST_CAP_MUL,
    ST_CAP_DIV,
    ST_CAP_WAIT,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic [RATE_W-1:0]          frac;
    logic [RATE_W-1:0]          den;
  } lane_req_t;

endpackage

FILE: src/rsmp_in_if.sv
// Input word channel: one audio frame per word.
interface rsmp_in_if;
  import rsmp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic                       frame_last;

  modport source (output valid, sample_a, sample_b, frame_last, input ready);
  modport sink (input valid, sample_a, sample_b, frame_last, output ready);
endinterface

FILE: src/rsmp_out_if.sv
// Output word channel: one resampled frame per word.
interface rsmp_out_if;
  import rsmp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_a;
  logic signed [SAMPLE_W-1:0] out_b;
  logic                       run_last;

  modport source (output valid, out_a, out_b, run_last, input ready);
  modport sink (input valid, out_a, out_b, run_last, output ready);
endinterface

FILE: src/linear_interp_resampler_core.sv
// Linear interpolation sample rate converter: a frame goes in, zero or more resampled frames come
// out. When the two rates are equal a frame is copied straight out. Otherwise the block first works
// out the clip total, then for each output frame it produces runs one shared position divider and
// the two channel lanes, each dividing one bit per cycle, then a position check ends the frame,
// with a further division when a run is cut at MAX_RUN outputs. One frame is worked on at a time;
// an output register lets the next result wait for the sink while the block goes on. There is no
// clearing pass after reset.
module linear_interp_resampler_core #(
  parameter int MAX_FRAMES_LOG2 = rsmp_pkg::MAX_FRAMES_LOG2_DEF,
  parameter int MAX_RUN         = rsmp_pkg::MAX_RUN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  rsmp_in_if.sink                          frames,
  rsmp_out_if.source                       results,
  input  logic                             cfg_wr_en,
  input  logic [rsmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsmp_pkg::RATE_W-1:0]      cfg_wr_data
);
  import rsmp_pkg::*;

  localparam int W    = MAX_FRAMES_LOG2;
  localparam int JW   = W + 1;
  localparam int PW   = JW + RATE_W;
  localparam int DNW  = PW + 1;
  localparam int DDW  = RATE_W + 1;
  localparam int RUNW = $clog2(MAX_RUN + 1);
  localparam logic [W-1:0] COUNT_MAX = {W{1'b1}};

  seq_state_t state, state_next;

  logic [RATE_W-1:0] src_rate, dst_rate;
  logic [CHAN_W-1:0] channel_count;
  logic [RATE_W-1:0] ti_cfg, to_cfg;
  logic [RATE_W-1:0] ti_q, to_q;

  logic signed [SAMPLE_W-1:0] a_q, b_q, prev_a, prev_b;
  logic signed [SAMPLE_W-1:0] val_a, val_b, pend_a, pend_b;
  logic                       last_q;
  logic                       pend_v;
  logic [W-1:0]               k_cnt;
  logic [W-1:0]               nframes;
  logic [JW-1:0]              oc;
  logic [RUNW-1:0]            n_cnt;

  logic [JW-1:0]     mul_a;
  logic [RATE_W-1:0] mul_b;
  logic [PW-1:0]     prod;
  logic [DNW-1:0]    div_num;
  logic [DDW-1:0]    div_den;
  logic              div_start, div_done;
  logic [DNW-1:0]    div_quot;
  logic [DDW-1:0]    div_rem;

  logic [DNW-1:0]    total;
  logic [DNW-1:0]    whole;
  logic [RATE_W-1:0] frac;
  logic [DNW-1:0]    first_pos;

  logic              room, oc_below, oc_next_end, run_full, whole_past, stop;
  logic              lane_start;
  logic [1:0]        lane_done;
  logic signed [SAMPLE_W-1:0] lane_val [2];
  lane_req_t         req_a, req_b;

  logic                       emit;
  logic signed [SAMPLE_W-1:0] emit_a, emit_b;
  logic                       emit_last;
  logic                       out_valid;

  // A rate register that holds zero is taken as one.
  assign ti_cfg = (src_rate == '0) ? RATE_W'(1) : src_rate;
  assign to_cfg = (dst_rate == '0) ? RATE_W'(1) : dst_rate;

  assign nframes     = (k_cnt == COUNT_MAX) ? COUNT_MAX : k_cnt + W'(1);
  assign room        = !out_valid || results.ready;
  assign oc_below    = DNW'(oc) < total;
  assign oc_next_end = (DNW'(oc) + DNW'(1)) == total;
  assign run_full    = n_cnt == RUNW'(MAX_RUN);
  assign whole_past  = whole >= DNW'(k_cnt);
  assign stop        = last_q ? !oc_below : whole_past;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rate      <= SRC_RATE_RST;
      dst_rate      <= DST_RATE_RST;
      channel_count <= CHANNELS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_RATE: src_rate      <= cfg_wr_data;
        CFG_DST_RATE: dst_rate      <= cfg_wr_data;
        CFG_CHANNELS: channel_count <= cfg_wr_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (frames.valid) state_next = (ti_cfg == to_cfg) ? ST_COPY : ST_TOT_MUL;
      ST_COPY:     if (room) state_next = ST_FINISH;
      ST_TOT_MUL:  state_next = ST_TOT_DIV;
      ST_TOT_DIV:  state_next = ST_TOT_WAIT;
      ST_TOT_WAIT: if (div_done) state_next = ST_PEND;
      ST_PEND: begin
        if (!pend_v) begin
          state_next = ST_POS_MUL;
        end else if (!oc_below) begin
          state_next = ST_FINISH;
        end else if (room) begin
          state_next = ST_POS_MUL;
        end
      end
      ST_POS_MUL:  state_next = ST_POS_DIV;
      ST_POS_DIV:  state_next = ST_POS_WAIT;
      ST_POS_WAIT: if (div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (stop) begin
          state_next = ST_FINISH;
        end else if (whole_past) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_BLEND;
        end
      end
      ST_BLEND:    if (lane_done[0]) state_next = ST_PLACE;
      ST_PLACE: begin
        if (!oc_below) begin
          state_next = ST_FINISH;
        end else if (run_full) begin
          state_next = last_q ? ST_FINISH : ST_CAP_MUL;
        end else if (room) begin
          state_next = ST_POS_MUL;
        end
      end
      ST_CAP_MUL:  state_next = ST_CAP_DIV;
      ST_CAP_DIV:  state_next = ST_CAP_WAIT;
      ST_CAP_WAIT: if (div_done) state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    frames.ready = 1'b0;
    div_start    = 1'b0;
    lane_start   = 1'b0;
    emit         = 1'b0;
    emit_a       = val_a;
    emit_b       = val_b;
    emit_last    = 1'b0;
    mul_a        = oc;
    mul_b        = ti_q;
    div_num      = DNW'(prod);
    div_den      = {1'b0, to_q};
    unique case (state)
      ST_IDLE: frames.ready = 1'b1;
      ST_COPY: begin
        emit      = room;
        emit_a    = a_q;
        emit_b    = b_q;
        emit_last = last_q;
      end
      ST_TOT_MUL: begin
        mul_a = JW'(nframes);
        mul_b = to_q;
      end
      ST_TOT_DIV: begin
        div_start = 1'b1;
        div_num   = {prod, 1'b0} + DNW'(ti_q);
        div_den   = {ti_q, 1'b0};
      end
      ST_PEND: begin
        emit      = pend_v && oc_below && room;
        emit_a    = pend_a;
        emit_b    = pend_b;
        emit_last = last_q && oc_next_end;
      end
      ST_POS_DIV:  div_start = 1'b1;
      ST_CHECK:    lane_start = !stop && !whole_past;
      ST_PLACE: begin
        emit      = oc_below && !run_full && room;
        emit_last = last_q && (oc_next_end || (n_cnt == RUNW'(MAX_RUN - 1)));
      end
      ST_CAP_MUL: begin
        mul_a = JW'(k_cnt);
        mul_b = to_q;
      end
      ST_CAP_DIV: begin
        div_start = 1'b1;
        div_num   = DNW'(prod) + DNW'(ti_q) - DNW'(1);
        div_den   = {1'b0, ti_q};
      end
      default: ;
    endcase
  end

  rsmp_div #(
    .NUM_W(DNW),
    .DEN_W(DDW)
  ) u_pos_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign req_a = '{start: lane_start, lo: prev_a, hi: a_q, frac: frac, den: to_q};
  assign req_b = '{start: lane_start, lo: prev_b, hi: b_q, frac: frac, den: to_q};

  rsmp_lane u_lane_a (
    .clk  (clk),
    .rst  (rst),
    .req  (req_a),
    .done (lane_done[0]),
    .value(lane_val[0])
  );

  rsmp_lane u_lane_b (
    .clk  (clk),
    .rst  (rst),
    .req  (req_b),
    .done (lane_done[1]),
    .value(lane_val[1])
  );

  // The cut run resumes at the first output whose left neighbor is the newest frame.
  assign first_pos = (div_quot > total) ? total : div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k_cnt     <= '0;
      oc        <= '0;
      pend_v    <= 1'b0;
      n_cnt     <= '0;
      last_q    <= 1'b0;
      prev_a    <= '0;
      prev_b    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frames.valid) begin
            last_q <= frames.frame_last;
            n_cnt  <= '0;
          end
        end
        ST_COPY: begin
          if (room) begin
            oc     <= JW'(nframes);
            pend_v <= 1'b0;
          end
        end
        ST_PEND: begin
          if (emit) begin
            oc     <= oc + JW'(1);
            n_cnt  <= n_cnt + RUNW'(1);
            pend_v <= 1'b0;
          end
        end
        ST_PLACE: begin
          if (emit) begin
            oc    <= oc + JW'(1);
            n_cnt <= n_cnt + RUNW'(1);
          end else if (!oc_below) begin
            pend_v <= 1'b1;
          end
        end
        ST_CAP_WAIT: begin
          if (div_done && first_pos > DNW'(oc)) begin
            oc <= (first_pos > DNW'(COUNT_MAX)) ? JW'(COUNT_MAX) : first_pos[JW-1:0];
          end
        end
        ST_FINISH: begin
          if (last_q) begin
            prev_a <= '0;
            prev_b <= '0;
            k_cnt  <= '0;
            oc     <= '0;
            pend_v <= 1'b0;
          end else begin
            prev_a <= a_q;
            prev_b <= b_q;
            k_cnt  <= nframes;
            oc     <= (oc > JW'(COUNT_MAX)) ? JW'(COUNT_MAX) : oc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && frames.valid) begin
      a_q  <= frames.sample_a;
      b_q  <= (channel_count != CHAN_MONO) ? frames.sample_b : '0;
      ti_q <= ti_cfg;
      to_q <= to_cfg;
    end
    if (state == ST_TOT_MUL || state == ST_POS_MUL || state == ST_CAP_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_TOT_WAIT && div_done) begin
      total <= div_quot;
    end
    if (state == ST_POS_WAIT && div_done) begin
      whole <= div_quot;
      frac  <= div_rem[RATE_W-1:0];
    end
    if (state == ST_CHECK) begin
      val_a <= a_q;
      val_b <= b_q;
    end
    if (state == ST_BLEND && lane_done[0]) begin
      val_a <= lane_val[0];
      val_b <= lane_val[1];
    end
    if (state == ST_PLACE && !oc_below) begin
      pend_a <= val_a;
      pend_b <= val_b;
    end
    if (emit) begin
      results.out_a    <= emit_a;
      results.out_b    <= emit_b;
      results.run_last <= emit_last;
    end
  end

  assign results.valid = out_valid;

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1])
    else $error("channel lanes finished out of step");

  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    frames.valid && frames.ready |=> !frames.ready)
    else $error("second frame taken while one is in work");

  a_clip_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && last_q |=> k_cnt == '0 && !pend_v && oc == '0)
    else $error("clip state not cleared after last frame");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    emit |-> room)
    else $error("result word written over an untaken word");
`endif
endmodule

FILE: src/rsmp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rsmp_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] pr;
  logic [DEN_W-1:0] dq;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {pr, sh[NUM_W-1]};
    ge    = trial >= {1'b0, dq};
    diff  = trial - {1'b0, dq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= num;
      pr <= '0;
      dq <= den;
    end else if (busy) begin
      sh <= {sh[NUM_W-2:0], ge};
      pr <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quot = sh;
  assign rem  = pr;
endmodule

FILE: src/rsmp_lane.sv
// One channel lane: blends two samples by a rational fraction, truncating toward zero.
module rsmp_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  rsmp_pkg::lane_req_t                 req,
  output logic                                done,
  output logic signed [rsmp_pkg::SAMPLE_W-1:0] value
);
  import rsmp_pkg::*;

  logic signed [BLEND_W-1:0]  p_base;
  logic signed [BLEND_W-1:0]  p_step;
  logic signed [SAMPLE_W:0]   delta;
  logic                       mul_v;
  logic signed [BLEND_W-1:0]  num;
  logic                       num_neg;
  logic [BLEND_W-1:0]         num_abs;
  logic                       neg_q;
  logic [BLEND_MAG_W-1:0]     quot;
  logic [RATE_W-1:0]          rem_unused;
  logic [SAMPLE_W-1:0]        q_lo;

  assign delta = {req.hi[SAMPLE_W-1], req.hi} - {req.lo[SAMPLE_W-1], req.lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      p_base <= req.lo * $signed({1'b0, req.den});
      p_step <= delta * $signed({1'b0, req.frac});
    end
    if (mul_v) begin
      neg_q <= num_neg;
    end
  end

  always_comb begin
    num     = p_base + p_step;
    num_neg = num[BLEND_W-1];
    num_abs = num_neg ? BLEND_W'(-num) : BLEND_W'(num);
  end

  rsmp_div #(
    .NUM_W(BLEND_MAG_W),
    .DEN_W(RATE_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(mul_v),
    .num  (num_abs[BLEND_MAG_W-1:0]),
    .den  (req.den),
    .done (done),
    .quot (quot),
    .rem  (rem_unused)
  );

  // The magnitude quotient never exceeds 32768, so the low bits carry it.
  assign q_lo  = quot[SAMPLE_W-1:0];
  assign value = neg_q ? $signed(-q_lo) : $signed(q_lo);
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the linear interpolation resampler core.
`timescale 1ns / 1ps

module tb_top;
  import rsmp_pkg::*;

  localparam int          CNT_W      = MAX_FRAMES_LOG2_DEF;
  localparam longint      COUNT_MAX  = (longint'(1) << CNT_W) - 1;
  localparam int          RUN_MAX    = MAX_RUN_DEF;
  localparam int          SETTLE     = 600;
  localparam longint      LIMIT      = 2_000_000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       last;
  } frame_t;

  logic clk;
  logic rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0]    cfg_wr_data;

  rsmp_in_if  frames_if ();
  rsmp_out_if results_if ();

  linear_interp_resampler_core dut (
    .clk        (clk),
    .rst        (rst),
    .frames     (frames_if),
    .results    (results_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state.
  longint unsigned in_rate, out_rate, chans;
  int              prev_a, prev_b;
  longint unsigned in_count, out_count;
  bit              held_valid;
  int              held_a, held_b;

  frame_t  expected_frames[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      steady_sink;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_clip();
    prev_a = 0;
    prev_b = 0;
    in_count = 0;
    out_count = 0;
    held_valid = 0;
    held_a = 0;
    held_b = 0;
  endfunction

  function automatic void push_frame(int a, int b);
    frame_t f;
    f.a = a[SAMPLE_W-1:0];
    f.b = b[SAMPLE_W-1:0];
    f.last = 1'b0;
    expected_frames.push_back(f);
  endfunction

  function automatic int lerp(int lo, int hi, longint unsigned frac, longint unsigned den);
    longint num;
    num = longint'(lo) * longint'(den) + (longint'(hi) - longint'(lo)) * longint'(frac);
    return int'(num / longint'(den));
  endfunction

  // Works out every output frame caused by one accepted input frame.
  function automatic void resample_frame(logic signed [SAMPLE_W-1:0] sa,
                                         logic signed [SAMPLE_W-1:0] sb, logic last);
    longint unsigned ti, to, k, nf, oc, total, j, whole, frac, first;
    bit stereo, capped;
    int a, b, va, vb, n;
    ti = (in_rate != 0) ? in_rate : 1;
    to = (out_rate != 0) ? out_rate : 1;
    stereo = (chans != 1);
    a = sa;
    b = stereo ? int'(sb) : 0;
    k = in_count;
    nf = (k < COUNT_MAX) ? k + 1 : COUNT_MAX;
    n = 0;
    capped = 0;
    if (ti == to) begin
      push_frame(a, b);
      n = 1;
      oc = nf;
      held_valid = 0;
    end else begin
      total = (2 * nf * to + ti) / (2 * ti);
      oc = out_count;
      if (held_valid && oc < total) begin
        push_frame(held_a, held_b);
        n++;
        oc++;
        held_valid = 0;
      end
      forever begin
        j = oc + (held_valid ? 1 : 0);
        whole = (j * ti) / to;
        frac = (j * ti) % to;
        if (last) begin
          if (j >= total) break;
        end else if (whole >= k) begin
          break;
        end
        if (whole >= k) begin
          va = a;
          vb = b;
        end else begin
          va = lerp(prev_a, a, frac, to);
          vb = lerp(prev_b, b, frac, to);
        end
        if (j < total) begin
          if (n >= RUN_MAX) begin
            capped = 1;
            break;
          end
          push_frame(va, vb);
          n++;
          oc++;
        end else begin
          if (held_valid) break;
          held_a = va;
          held_b = vb;
          held_valid = 1;
        end
      end
      if (capped) begin
        if (last) begin
          oc = total;
        end else begin
          first = (k * to + ti - 1) / ti;
          if (first > total) first = total;
          if (first > oc) oc = first;
        end
      end
    end
    if (last && n > 0) expected_frames[expected_frames.size()-1].last = 1'b1;
    prev_a = a;
    prev_b = b;
    in_count = nf;
    out_count = (oc > COUNT_MAX) ? COUNT_MAX : oc;
    if (last) clear_clip();
  endfunction

  // Result checker.
  always @(posedge clk) begin
    frame_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected word a=%0d b=%0d last=%0b", results_if.out_a,
                                  results_if.out_b, results_if.run_last));
      end else begin
        want = expected_frames.pop_front();
        if (results_if.out_a !== want.a)
          report_mismatch($sformatf("out_a %0d, want %0d", results_if.out_a, want.a));
        if (results_if.out_b !== want.b)
          report_mismatch($sformatf("out_b %0d, want %0d", results_if.out_b, want.b));
        if (results_if.run_last !== want.last)
          report_mismatch($sformatf("run_last %0b, want %0b", results_if.run_last, want.last));
      end
    end
  end

  // Sink back-pressure in random bursts, held off while steady_sink is set.
  initial begin
    int len;
    bit rdy;
    results_if.ready = 1'b0;
    forever begin
      rdy = steady_sink ? 1'b1 : ($urandom_range(0, 2) != 0);
      len = $urandom_range(1, 16);
      repeat (len) begin
        @(posedge clk);
        results_if.ready <= rdy | steady_sink;
      end
    end
  end

  // Sends one frame; valid stays high afterwards until the next call or a drain.
  task automatic send_frame(input int sa, input int sb, input bit last);
    logic signed [SAMPLE_W-1:0] xa, xb;
    xa = SAMPLE_W'(sa);
    xb = SAMPLE_W'(sb);
    if (!steady_sink && $urandom_range(0, 3) == 0) begin
      frames_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    frames_if.valid <= 1'b1;
    frames_if.sample_a <= xa;
    frames_if.sample_b <= xb;
    frames_if.frame_last <= last;
    do @(posedge clk); while (!frames_if.ready);
    resample_frame(xa, xb, last);
  endtask

  // Stops sending and waits until the block has delivered everything and settled.
  task automatic drain();
    frames_if.valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val[RATE_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SRC_RATE: in_rate = val & 'h3FFFF;
      CFG_DST_RATE: out_rate = val & 'h3FFFF;
      CFG_CHANNELS: chans = val & 'h3;
      default: ;
    endcase
  endtask

  task automatic set_rates(input longint unsigned ri, input longint unsigned ro);
    cfg_write(CFG_SRC_RATE, ri);
    cfg_write(CFG_DST_RATE, ro);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic test_copy();
    send_frame(32767, -32768, 1'b0);
    send_frame(-32768, 32767, 1'b0);
    send_frame(0, -1, 1'b0);
    send_frame(1, 0, 1'b1);
  endtask

  task automatic test_zero_rate();
    set_rates(0, 0);
    send_frame(100, -100, 1'b0);
    send_frame(-5, 7, 1'b1);
    cfg_write(CFG_DST_RATE, 3);
    send_frame(32767, -32768, 1'b0);
    send_frame(-32768, 32767, 1'b1);
  endtask

  task automatic test_channels();
    set_rates(2, 3);
    cfg_write(CFG_CHANNELS, CHAN_MONO);
    send_frame(1234, -4321, 1'b0);
    send_frame(-30000, 30000, 1'b1);
    cfg_write(CFG_CHANNELS, 3);
    send_frame(-7, 32767, 1'b0);
    send_frame(9, -32768, 1'b1);
    cfg_write(CFG_CHANNELS, 0);
  endtask

  // Downsampling by more than two holds an output back until the total allows it.
  task automatic test_held_output();
    set_rates(48000, 10000);
    for (int i = 0; i < 5; i++) send_frame(i * 5000 - 12000, 9000 - i * 3000, 1'b0);
    // Pause until the block has nothing left to deliver.
    drain();
    send_frame(32767, -32768, 1'b1);
  endtask

  task automatic test_empty_end();
    set_rates(4, 1);
    send_frame(555, -555, 1'b1);
  endtask

  // Extreme ratios: a huge upsample hits the run cap, a huge downsample yields nothing.
  task automatic test_run_cap();
    set_rates(1, 192000);
    send_frame(-32768, 32767, 1'b0);
    send_frame(32767, -32768, 1'b0);
    send_frame(100, 200, 1'b1);
    set_rates(192000, 1);
    send_frame(1, 2, 1'b0);
    send_frame(3, 4, 1'b1);
  endtask

  task automatic test_midclip_write();
    set_rates(3, 2);
    send_frame(1000, -1000, 1'b0);
    send_frame(2000, -2000, 1'b0);
    cfg_write(CFG_DST_RATE, 5);
    send_frame(-3000, 3000, 1'b0);
    send_frame(4000, -4000, 1'b1);
  endtask

  task automatic test_random();
    int sent, len;
    longint unsigned ri, ro;
    sent = 0;
    while (sent < 92) begin
      ri = $urandom_range(1, 192000);
      case ($urandom_range(0, 4))
        0: ro = ri;
        1: ro = ri + $urandom_range(0, ri);
        2: ro = ri / 2 + $urandom_range(0, ri / 2);
        3: ro = ri / $urandom_range(3, 6);
        default: ro = $urandom_range(1, 192000);
      endcase
      if (ro == 0) ro = 1;
      if (ro > 192000) ro = 192000;
      if (ro > 3 * ri) ro = 3 * ri;
      if ($urandom_range(0, 2) != 0) begin
        set_rates(ri, ro);
        cfg_write(CFG_CHANNELS, $urandom_range(0, 3));
      end
      len = $urandom_range(1, 10);
      if (sent >= 72) steady_sink = 1;
      for (int i = 0; i < len; i++) begin
        // An occasional stray last mark breaks a clip early.
        send_frame(rand_sample(), rand_sample(), (i == len - 1) || ($urandom_range(0, 19) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    steady_sink = 0;
    in_rate = 48000;
    out_rate = 48000;
    chans = 2;
    clear_clip();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SRC_RATE;
    cfg_wr_data = '0;
    frames_if.valid = 1'b0;
    frames_if.sample_a = '0;
    frames_if.sample_b = '0;
    frames_if.frame_last = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_copy();
    test_zero_rate();
    test_channels();
    test_held_output();
    test_empty_end();
    test_run_cap();
    test_midclip_write();
    test_random();
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
